>>> rtl/cobs_spf_pkg.sv
// ----------------------------------------------------------------------------
// COBS signal packet filter package
// Shared types and constants for the streaming COBS decoder and type filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cobs_spf_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 255;

    localparam logic [7:0]  CODE_NO_ZERO      = 8'hFF;
    localparam logic [7:0]  LEN_CAP           = 8'd250;
    localparam logic [8:0]  RAW_COUNT_MAX     = 9'd511;
    localparam logic [7:0]  DEC_COUNT_MAX     = 8'd255;
    localparam logic [8:0]  MIN_RAW_BYTES     = 9'd5;
    localparam logic [7:0]  TYPE_BYTES        = 8'd4;

    localparam logic [31:0] ACCEPT_MASK_RESET = 32'hFFFF_FFFF;
    localparam logic [7:0]  MAX_PAYLOAD_RESET = 8'd250;

    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ACCEPT_MASK = 1'b0,
        CFG_MAX_PAYLOAD = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERLONG = 2'd1,
        ST_TOO_BIG  = 2'd2
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_SUMMARY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  payload_byte;
        logic [31:0] signal_type;
        logic [7:0]  payload_length;
        t_status     status;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/cobs_signal_packet_filter.sv
// ----------------------------------------------------------------------------
// COBS signal packet filter
// Streaming COBS decoder with little-endian packet type filter and
// end-of-packet summary.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-------------------------------
//  stream   | in        | i_valid / o_stall  | i_stream_byte
//  result   | out       | o_valid / i_stall  | o_item_kind .. o_last
//  config   | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
//  One stream byte per cycle while o_stall is low; its result is registered
//  into the result register, or into the skid register while the result
//  register is held. The two-entry output keeps o_stall registered;
//  o_stall rises only once both hold results. Synchronous active-low reset
//  clears packet state, the output stage and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module cobs_signal_packet_filter
    import cobs_spf_pkg::*;
#(
    parameter int unsigned MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [7:0]              i_stream_byte,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic                         o_item_kind,
    output logic [7:0]                   o_payload_byte,
    output logic [31:0]                  o_signal_type,
    output logic [7:0]                   o_payload_length,
    output logic [1:0]                   o_status,
    output logic                         o_last
);

    localparam logic [8:0] MAX_RAW = 9'(MAX_PACKET_BYTES);

    logic [31:0] r_accept_mask;
    logic [7:0]  r_max_payload;

    logic        r_expect_code, n_expect_code;
    logic [7:0]  r_block_remaining, n_block_remaining;
    logic        r_pending_zero, n_pending_zero;
    logic [8:0]  r_raw_count, n_raw_count;
    logic [7:0]  r_decoded_count, n_decoded_count;
    logic [31:0] r_type_accum, n_type_accum;
    logic        r_type_matched, n_type_matched;

    t_result     r_out, r_skid, res;
    logic        r_out_valid, r_skid_valid;
    logic        res_valid;

    logic        accept;
    logic        out_fire;
    logic        take;
    logic [7:0]  dec_byte;
    logic [7:0]  len_raw;
    logic [7:0]  len;
    logic [31:0] type_next;

    assign accept   = i_valid && !r_skid_valid;
    assign out_fire = r_out_valid && !i_stall;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accept_mask <= ACCEPT_MASK_RESET;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ACCEPT_MASK: r_accept_mask <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[7:0];
            endcase
        end
    end

    // decode step
    always_comb begin
        n_expect_code     = r_expect_code;
        n_block_remaining = r_block_remaining;
        n_pending_zero    = r_pending_zero;
        n_raw_count       = r_raw_count;
        n_decoded_count   = r_decoded_count;
        n_type_accum      = r_type_accum;
        n_type_matched    = r_type_matched;
        take              = 1'b0;
        dec_byte          = 8'd0;
        type_next         = r_type_accum;
        len_raw           = r_decoded_count - TYPE_BYTES;
        len               = (len_raw > LEN_CAP) ? LEN_CAP : len_raw;
        res_valid         = 1'b0;
        res               = '{kind: KIND_PAYLOAD, payload_byte: 8'd0,
                              signal_type: r_type_accum, payload_length: 8'd0,
                              status: ST_OK, last: 1'b0};

        if (i_stream_byte == 8'd0) begin
            if (r_raw_count >= MIN_RAW_BYTES && r_decoded_count >= TYPE_BYTES
                    && r_type_matched) begin
                res_valid          = 1'b1;
                res.kind           = KIND_SUMMARY;
                res.payload_length = len;
                res.last           = 1'b1;
                if (r_raw_count > MAX_RAW) begin
                    res.status = ST_OVERLONG;
                end else if (len > r_max_payload) begin
                    res.status = ST_TOO_BIG;
                end else begin
                    res.status = ST_OK;
                end
            end
            n_expect_code     = 1'b1;
            n_block_remaining = 8'd0;
            n_pending_zero    = 1'b0;
            n_raw_count       = 9'd0;
            n_decoded_count   = 8'd0;
            n_type_accum      = 32'd0;
            n_type_matched    = 1'b0;
        end else begin
            if (r_raw_count != RAW_COUNT_MAX) begin
                n_raw_count = r_raw_count + 9'd1;
            end
            if (r_expect_code) begin
                take              = r_pending_zero;
                dec_byte          = 8'd0;
                n_pending_zero    = (i_stream_byte != CODE_NO_ZERO);
                n_block_remaining = i_stream_byte - 8'd1;
                n_expect_code     = (i_stream_byte == 8'd1);
            end else begin
                take              = 1'b1;
                dec_byte          = i_stream_byte;
                n_block_remaining = (r_block_remaining != 8'd0) ?
                                    r_block_remaining - 8'd1 : 8'd0;
                n_expect_code     = (r_block_remaining <= 8'd1);
            end

            if (take) begin
                if (r_decoded_count < TYPE_BYTES) begin
                    type_next = r_type_accum
                              | ({24'd0, dec_byte} << {r_decoded_count[1:0], 3'b000});
                    n_type_accum = type_next;
                    if (r_decoded_count[1:0] == 2'd3) begin
                        n_type_matched = ((type_next & r_accept_mask) != 32'd0);
                    end
                end else if (r_type_matched) begin
                    res_valid        = 1'b1;
                    res.payload_byte = dec_byte;
                end
                if (r_decoded_count != DEC_COUNT_MAX) begin
                    n_decoded_count = r_decoded_count + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_code     <= 1'b1;
            r_block_remaining <= 8'd0;
            r_pending_zero    <= 1'b0;
            r_raw_count       <= 9'd0;
            r_decoded_count   <= 8'd0;
            r_type_accum      <= 32'd0;
            r_type_matched    <= 1'b0;
        end else if (accept) begin
            r_expect_code     <= n_expect_code;
            r_block_remaining <= n_block_remaining;
            r_pending_zero    <= n_pending_zero;
            r_raw_count       <= n_raw_count;
            r_decoded_count   <= n_decoded_count;
            r_type_accum      <= n_type_accum;
            r_type_matched    <= n_type_matched;
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (accept && res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out       <= res;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res;
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stall          = r_skid_valid;
    assign o_valid          = r_out_valid;
    assign o_item_kind      = r_out.kind;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_signal_type    = r_out.signal_type;
    assign o_payload_length = r_out.payload_length;
    assign o_status         = r_out.status;
    assign o_last           = r_out.last;

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while result register empty");

    a_dec_le_raw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_decoded_count} <= r_raw_count)
        else $error("decoded count ahead of raw count");

    a_block_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_expect_code |-> r_block_remaining != 8'd0)
        else $error("inside a block with nothing remaining");

    a_delim_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_stream_byte == 8'd0 |=>
            r_raw_count == 9'd0 && r_expect_code && !r_type_matched)
        else $error("packet state not cleared after delimiter");
`endif

endmodule

`default_nettype wire
